// File: hw/rtl/i2p_pkg.sv
// ----------------------------------------------------------------------------
// i2p_pkg: shared types, constants and helpers of the infix to postfix block
// Character constants, operator codes, priorities and controller commands.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned CODE_W          = 3;

  localparam logic [7:0] CH_OPEN  = 8'h28;  // '('
  localparam logic [7:0] CH_CLOSE = 8'h29;  // ')'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [7:0] CH_MUL   = 8'h2A;  // '*'
  localparam logic [7:0] CH_DIV   = 8'h2F;  // '/'
  localparam logic [7:0] CH_POW   = 8'h5E;  // '^'
  localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '

  localparam logic [CODE_W-1:0] CODE_OPEN  = 3'd0;
  localparam logic [CODE_W-1:0] CODE_PLUS  = 3'd1;
  localparam logic [CODE_W-1:0] CODE_MINUS = 3'd2;
  localparam logic [CODE_W-1:0] CODE_MUL   = 3'd3;
  localparam logic [CODE_W-1:0] CODE_DIV   = 3'd4;
  localparam logic [CODE_W-1:0] CODE_POW   = 3'd5;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_UNDERFLOW = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW  = 2'd2;

  typedef enum logic [2:0] {
    CLS_DIGIT,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OP,
    CLS_OTHER
  } cls_t;

  typedef enum logic [1:0] {
    SEL_CH,
    SEL_SPACE,
    SEL_TOP,
    SEL_END
  } emit_sel_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_CHAR,
    ST_CLOSE,
    ST_OPPOP,
    ST_LCLOSE,
    ST_END
  } state_t;

  typedef struct packed {
    logic      load;
    logic      start;
    logic      push;
    logic      push_open;
    logic      pop;
    logic      set_uf;
    logic      emit;
    emit_sel_t sel;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic first;
    logic last;
    logic empty;
    logic top_open;
    logic prio_le;
    logic slot_free;
  } sts_t;

  function automatic cls_t char_class(input logic [7:0] c);
    cls_t r;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = CLS_DIGIT;
    end else if (c == CH_OPEN) begin
      r = CLS_OPEN;
    end else if (c == CH_CLOSE) begin
      r = CLS_CLOSE;
    end else if (c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
                 c == CH_POW) begin
      r = CLS_OP;
    end else begin
      r = CLS_OTHER;
    end
    return r;
  endfunction

  function automatic logic [CODE_W-1:0] op_code(input logic [7:0] c);
    logic [CODE_W-1:0] r;
    priority case (c)
      CH_PLUS:  r = CODE_PLUS;
      CH_MINUS: r = CODE_MINUS;
      CH_MUL:   r = CODE_MUL;
      CH_DIV:   r = CODE_DIV;
      CH_POW:   r = CODE_POW;
      default:  r = CODE_OPEN;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input logic [CODE_W-1:0] code);
    logic [7:0] r;
    priority case (code)
      CODE_OPEN:  r = CH_OPEN;
      CODE_PLUS:  r = CH_PLUS;
      CODE_MINUS: r = CH_MINUS;
      CODE_MUL:   r = CH_MUL;
      CODE_DIV:   r = CH_DIV;
      CODE_POW:   r = CH_POW;
      default:    r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] code_prio(input logic [CODE_W-1:0] code);
    logic [1:0] r;
    priority case (code)
      CODE_PLUS, CODE_MINUS: r = 2'd1;
      CODE_MUL, CODE_DIV:    r = 2'd2;
      CODE_POW:              r = 2'd3;
      default:               r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/i2p_if.sv
// ----------------------------------------------------------------------------
// i2p_if: channel interfaces of the infix to postfix block
// Valid/ready channels for input characters and for postfix results.
// ----------------------------------------------------------------------------
interface i2p_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       first;
  logic       last;

  modport source (output valid, output ch, output first, output last, input ready);
  modport sink   (input valid, input ch, input first, input last, output ready);
endinterface

interface i2p_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       is_end;
  logic [1:0] status;

  modport source (output valid, output out_char, output is_end, output status,
                  input ready);
  modport sink   (input valid, input out_char, input is_end, input status,
                  output ready);
endinterface

// File: hw/rtl/infix_to_postfix_converter.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// One ASCII character is accepted per input beat, with first and last marks
// framing an expression. Digits leave at once, operators are reordered on an
// operator stack, and the last character closes the expression with an end
// beat that carries the error status (0 ok, 1 underflow, 2 overflow).
//
// The input is taken only while the sequencer is idle. A digit or ignored
// character passes through accept, the start-mark step (spent even without
// the mark) and handling. Each popped operator adds a step, an operator
// one more for its push, a close paren one for removing its open paren, and
// the last mark adds its implicit-close pops, a step to remove the open
// paren and one for the end beat. The top entry and the one below it sit in
// registers, so a pop never waits on the stack memory.
// Results pass through one output register: a new input can be accepted
// while a result waits, and the sequencer holds when the register is full
// and the receiver is not ready. Reset empties the stack, clears the error
// and drops any pending result; stack contents need no clearing.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  i2p_in_if.sink    in_chan,
  i2p_out_if.source out_chan
);

  i2p_pkg::cmd_t cmd;
  i2p_pkg::sts_t sts;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  i2p_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_chan.ch),
    .in_first   (in_chan.first),
    .in_last    (in_chan.last),
    .cmd        (cmd),
    .sts        (sts),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_char   (out_chan.out_char),
    .out_is_end (out_chan.is_end),
    .out_status (out_chan.status)
  );

endmodule

// File: hw/rtl/i2p_ctrl.sv
// ----------------------------------------------------------------------------
// i2p_ctrl: sequencer of the infix to postfix block
// Steps through start, character handling and the pop loops, one stack
// operation and at most one output beat per cycle.
// ----------------------------------------------------------------------------
module i2p_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  i2p_pkg::sts_t sts,
  output i2p_pkg::cmd_t cmd
);

  i2p_pkg::state_t state_r;
  i2p_pkg::state_t state_nxt;
  i2p_pkg::state_t after_st;
  i2p_pkg::state_t close_done_st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2p_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    after_st      = sts.last ? i2p_pkg::ST_LCLOSE : i2p_pkg::ST_IDLE;
    close_done_st = (state_r == i2p_pkg::ST_CLOSE) ? after_st : i2p_pkg::ST_END;
    state_nxt     = state_r;
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.sel       = i2p_pkg::SEL_CH;

    unique case (state_r)
      i2p_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = i2p_pkg::ST_START;
        end
      end
      i2p_pkg::ST_START: begin
        // A start mark clears the stack and opens with an implicit paren.
        if (sts.first) begin
          cmd.start = 1'b1;
        end
        state_nxt = i2p_pkg::ST_CHAR;
      end
      i2p_pkg::ST_CHAR: begin
        unique case (sts.cls)
          i2p_pkg::CLS_DIGIT: begin
            if (sts.slot_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = i2p_pkg::SEL_CH;
              state_nxt = after_st;
            end
          end
          i2p_pkg::CLS_OPEN: begin
            cmd.push      = 1'b1;
            cmd.push_open = 1'b1;
            state_nxt     = after_st;
          end
          i2p_pkg::CLS_CLOSE: begin
            state_nxt = i2p_pkg::ST_CLOSE;
          end
          i2p_pkg::CLS_OP: begin
            if (sts.slot_free) begin
              cmd.emit  = 1'b1;
              cmd.sel   = i2p_pkg::SEL_SPACE;
              state_nxt = i2p_pkg::ST_OPPOP;
            end
          end
          i2p_pkg::CLS_OTHER: begin
            state_nxt = after_st;
          end
        endcase
      end
      i2p_pkg::ST_CLOSE, i2p_pkg::ST_LCLOSE: begin
        priority if (sts.empty) begin
          cmd.set_uf = 1'b1;
          state_nxt  = close_done_st;
        end else if (sts.top_open) begin
          cmd.pop   = 1'b1;
          state_nxt = close_done_st;
        end else begin
          cmd.emit = sts.slot_free;
          cmd.sel  = i2p_pkg::SEL_TOP;
          cmd.pop  = sts.slot_free;
        end
      end
      i2p_pkg::ST_OPPOP: begin
        priority if (sts.empty) begin
          cmd.set_uf = 1'b1;
          cmd.push   = 1'b1;
          state_nxt  = after_st;
        end else if (!sts.prio_le) begin
          cmd.push  = 1'b1;
          state_nxt = after_st;
        end else begin
          cmd.emit = sts.slot_free;
          cmd.sel  = i2p_pkg::SEL_TOP;
          cmd.pop  = sts.slot_free;
        end
      end
      i2p_pkg::ST_END: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          cmd.sel   = i2p_pkg::SEL_END;
          state_nxt = i2p_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = i2p_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hw/rtl/i2p_dpath.sv
// ----------------------------------------------------------------------------
// i2p_dpath: datapath of the infix to postfix block
// Holds the current character, the operator stack with its count, the sticky
// error and the output register.
// ----------------------------------------------------------------------------
module i2p_dpath #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic [7:0]    in_ch,
  input  logic          in_first,
  input  logic          in_last,
  input  i2p_pkg::cmd_t cmd,
  output i2p_pkg::sts_t sts,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_char,
  output logic          out_is_end,
  output logic [1:0]    out_status
);

  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AW = $clog2(STACK_DEPTH);

  logic [i2p_pkg::CODE_W-1:0] mem [STACK_DEPTH];

  logic [7:0]                 ch_r;
  logic                       first_r;
  logic                       last_r;
  logic [CW-1:0]              count_r, count_nxt;
  logic [i2p_pkg::CODE_W-1:0] top_r, top_nxt;
  logic [i2p_pkg::CODE_W-1:0] second_r;
  logic [1:0]                 err_r, err_nxt;
  logic                       out_valid_r;
  logic [7:0]                 out_char_r;
  logic                       out_is_end_r;
  logic [1:0]                 out_status_r;

  logic                       full;
  logic                       push_ok;
  logic [i2p_pkg::CODE_W-1:0] push_code;
  logic                       mem_we;
  logic [AW-1:0]              wr_addr;
  logic [i2p_pkg::CODE_W-1:0] wr_data;
  logic                       rd_en;
  logic [CW-1:0]              rd_cnt;
  logic                       slot_free;

  assign full      = (count_r == CW'(STACK_DEPTH));
  assign push_code = cmd.push_open ? i2p_pkg::CODE_OPEN : i2p_pkg::op_code(ch_r);
  assign push_ok   = cmd.push && !full;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    err_nxt   = err_r;
    mem_we    = 1'b0;
    wr_addr   = count_r[AW-1:0];
    wr_data   = push_code;
    if (cmd.start) begin
      count_nxt = CW'(1);
      top_nxt   = i2p_pkg::CODE_OPEN;
      err_nxt   = i2p_pkg::STATUS_OK;
      mem_we    = 1'b1;
      wr_addr   = '0;
      wr_data   = i2p_pkg::CODE_OPEN;
    end else if (push_ok) begin
      count_nxt = count_r + CW'(1);
      top_nxt   = push_code;
      mem_we    = 1'b1;
    end else if (cmd.pop) begin
      count_nxt = count_r - CW'(1);
      top_nxt   = second_r;
    end
    // The first error of an expression is kept.
    if (!cmd.start && err_r == i2p_pkg::STATUS_OK) begin
      if (cmd.set_uf) begin
        err_nxt = i2p_pkg::STATUS_UNDERFLOW;
      end else if (cmd.push && full) begin
        err_nxt = i2p_pkg::STATUS_OVERFLOW;
      end
    end
  end

  // The entry below the new top is fetched while at least two entries remain, so
  // that a pop can take its successor from second_r without waiting on the memory.
  assign rd_en  = (count_nxt >= CW'(2));
  assign rd_cnt = count_nxt - CW'(2);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      second_r <= mem[rd_cnt[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      err_r       <= i2p_pkg::STATUS_OK;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      err_r   <= err_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    if (cmd.load) begin
      ch_r    <= in_ch;
      first_r <= in_first;
      last_r  <= in_last;
    end
    if (cmd.emit) begin
      out_is_end_r <= 1'b0;
      out_status_r <= i2p_pkg::STATUS_OK;
      unique case (cmd.sel)
        i2p_pkg::SEL_CH:    out_char_r <= ch_r;
        i2p_pkg::SEL_SPACE: out_char_r <= i2p_pkg::CH_SPACE;
        i2p_pkg::SEL_TOP:   out_char_r <= i2p_pkg::code_char(top_r);
        i2p_pkg::SEL_END: begin
          out_char_r   <= 8'h00;
          out_is_end_r <= 1'b1;
          out_status_r <= err_r;
        end
      endcase
    end
  end

  always_comb begin
    sts.cls       = i2p_pkg::char_class(ch_r);
    sts.first     = first_r;
    sts.last      = last_r;
    sts.empty     = (count_r == '0);
    sts.top_open  = (top_r == i2p_pkg::CODE_OPEN);
    sts.prio_le   = (i2p_pkg::code_prio(i2p_pkg::op_code(ch_r)) <=
                     i2p_pkg::code_prio(top_r));
    sts.slot_free = slot_free;
  end

  assign out_valid  = out_valid_r;
  assign out_char   = out_char_r;
  assign out_is_end = out_is_end_r;
  assign out_status = out_status_r;

endmodule
